[src/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Types and constants shared by the servo pluck timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int TIME_W   = 32;
  localparam int PULSE_W  = 12;
  localparam int HOME_W   = 8;
  localparam int PROD_W   = 20;
  localparam int CFG_W    = 64;
  localparam int REG_W    = 3;
  localparam int MAX_SERVOS = 16;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_NOTE = 1'b1
  } cmd_e;

  typedef enum logic [REG_W-1:0] {
    REG_PLUCK_DEG     = 3'd0,
    REG_PLUCK_HOLD    = 3'd1,
    REG_POWER_HOLD    = 3'd2,
    REG_DIRECTION     = 3'd3,
    REG_HOME_LOW      = 3'd4,
    REG_HOME_HIGH     = 3'd5,
    REG_PULSE_MIN     = 3'd6,
    REG_PULSE_MAX     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    cmd_e        command;
    logic [5:0]  servo_select;
  } in_req_t;

  typedef struct packed {
    logic               write_valid;
    logic [3:0]         servo_index;
    logic [PULSE_W-1:0] pulse_count;
    logic               outputs_enabled;
    logic               last;
  } out_res_t;

  typedef struct packed {
    logic [6:0]         pluck_deg;
    logic [15:0]        pluck_hold_ms;
    logic [15:0]        power_hold_ms;
    logic [15:0]        direction_mask;
    logic [63:0]        home_angles_low;
    logic [63:0]        home_angles_high;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
  } cfg_t;

  localparam logic [6:0]         RST_PLUCK_DEG   = 7'd20;
  localparam logic [15:0]        RST_PLUCK_HOLD  = 16'd150;
  localparam logic [15:0]        RST_POWER_HOLD  = 16'd1000;
  localparam logic [15:0]        RST_DIRECTION   = 16'd0;
  localparam logic [63:0]        RST_HOME        = 64'h5A5A_5A5A_5A5A_5A5A;
  localparam logic [PULSE_W-1:0] RST_PULSE_MIN   = 12'd150;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX   = 12'd600;

endpackage

`default_nettype wire

[src/spt_cfg.sv]
// ----------------------------------------------------------------------------
// spt_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [spt_pkg::REG_W-1:0] cfg_idx_i,
  input  wire logic [spt_pkg::CFG_W-1:0] cfg_wdata_i,
  output spt_pkg::cfg_t                 cfg_o
);
  import spt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PLUCK_DEG:   cfg_d.pluck_deg        = cfg_wdata_i[6:0];
        REG_PLUCK_HOLD:  cfg_d.pluck_hold_ms    = cfg_wdata_i[15:0];
        REG_POWER_HOLD:  cfg_d.power_hold_ms    = cfg_wdata_i[15:0];
        REG_DIRECTION:   cfg_d.direction_mask   = cfg_wdata_i[15:0];
        REG_HOME_LOW:    cfg_d.home_angles_low  = cfg_wdata_i;
        REG_HOME_HIGH:   cfg_d.home_angles_high = cfg_wdata_i;
        REG_PULSE_MIN:   cfg_d.pulse_min        = cfg_wdata_i[PULSE_W-1:0];
        REG_PULSE_MAX:   cfg_d.pulse_max        = cfg_wdata_i[PULSE_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pluck_deg        <= RST_PLUCK_DEG;
      cfg_q.pluck_hold_ms    <= RST_PLUCK_HOLD;
      cfg_q.power_hold_ms    <= RST_POWER_HOLD;
      cfg_q.direction_mask   <= RST_DIRECTION;
      cfg_q.home_angles_low  <= RST_HOME;
      cfg_q.home_angles_high <= RST_HOME;
      cfg_q.pulse_min        <= RST_PULSE_MIN;
      cfg_q.pulse_max        <= RST_PULSE_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/spt_div.sv]
// ----------------------------------------------------------------------------
// spt_div
// Unsigned division by a constant through a reciprocal multiply: capture the
// operand on start, multiply by the rounded-up reciprocal the next cycle, and
// present the quotient with done_o in the cycle after that. Exact for every
// DW-bit operand.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_div #(
  parameter int DW      = 20,
  parameter int DIVISOR = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int LW = $clog2(DIVISOR);
  localparam int SH = DW + LW;
  localparam int MW = SH + 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic             pend_q, pend_d;
  logic             done_q, done_d;
  logic [DW-1:0]    num_q;
  logic [DW-1:0]    quo_q;
  logic [DW+MW-1:0] prod;

  assign prod   = num_q * RECIP;
  assign pend_d = start_i;
  assign done_d = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (pend_q) begin
      quo_q <= prod[SH +: DW];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[src/servo_pluck_timer_bank_top.sv]
// ----------------------------------------------------------------------------
// servo_pluck_timer_bank_top
// Bank of plucking servos with return timers, power hold and pulse mapping.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_req_i  (spt_pkg::in_req_t)
//   out       output     out_valid_o / out_ready_i out_res_o (spt_pkg::out_res_t)
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// After acceptance a note runs a multiply, the division by the angle span in
// the reciprocal divider (skipped if the span is not positive) and an output
// load; an out-of-range note goes straight to the output load. A tick scans
// every servo, one compare each, takes a power step, then loads the output if
// nothing expired, or picks each expired servo and sends it home as for a note.
// in_ready_o is high only while idle; a full output register stalls the push.
// Reset clears time, activity and power state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pluck_timer_bank_top #(
  parameter int SERVO_COUNT = 16,
  parameter int ANGLE_MIN   = 0,
  parameter int ANGLE_MAX   = 180
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire spt_pkg::in_req_t          in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output spt_pkg::out_res_t              out_res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [spt_pkg::REG_W-1:0] cfg_idx_i,
  input  wire logic [spt_pkg::CFG_W-1:0] cfg_wdata_i
);
  import spt_pkg::*;

  localparam int IW      = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int SPAN    = ANGLE_MAX - ANGLE_MIN;
  localparam bit SPAN_OK = SPAN > 0;
  localparam int DIVISOR = SPAN_OK ? SPAN : 1;
  localparam logic signed [9:0] AMIN_S  = 10'(ANGLE_MIN);
  localparam logic signed [9:0] AMAX_S  = 10'(ANGLE_MAX);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_FIN  = 7'b0000100,
    ST_PICK = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_PUSH = 7'b1000000
  } state_e;

  cfg_t cfg;

  state_e                   state_q, state_d;
  logic [TIME_W-1:0]        time_q, time_d;
  logic [TIME_W-1:0]        pdl_q, pdl_d;
  logic                     pwr_q, pwr_d;
  logic [SERVO_COUNT-1:0]   active_q, active_d;
  logic [SERVO_COUNT-1:0]   mask_q, mask_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic                     note_q, note_d;
  logic                     wv_q, wv_d;
  logic                     last_q, last_d;
  logic                     neg_q, neg_d;
  logic [PULSE_W-1:0]       pulse_q, pulse_d;
  logic                     out_valid_q, out_valid_d;
  out_res_t                 out_q, out_d;
  logic [TIME_W-1:0]        rdl_q [SERVO_COUNT];
  logic                     rdl_we;
  logic [IW-1:0]            rdl_idx;
  logic [TIME_W-1:0]        rdl_wdata;

  logic                     accept;
  logic                     sel_ok;
  logic [IW-1:0]            sel_idx;
  logic [TIME_W-1:0]        ret_diff;
  logic [TIME_W-1:0]        pwr_diff;
  logic [SERVO_COUNT-1:0]   rest;
  logic [127:0]             home_all;
  logic [HOME_W-1:0]        home;
  logic signed [9:0]        ang_raw;
  logic signed [9:0]        ang_sat;
  logic [HOME_W-1:0]        ang_off;
  logic signed [12:0]       pdiff;
  logic signed [21:0]       prod;
  logic [21:0]              prod_abs;
  logic                     div_start;
  logic                     div_done;
  logic [PROD_W-1:0]        div_quo;
  logic [PULSE_W-1:0]       q_lo;
  logic                     out_free;

  spt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  spt_div #(
    .DW      (PROD_W),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_abs[PROD_W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign sel_ok     = in_req_i.servo_select < 6'(SERVO_COUNT);
  assign sel_idx    = in_req_i.servo_select[IW-1:0];
  assign out_free   = !out_valid_q || out_ready_i;
  assign ret_diff   = time_q - rdl_q[idx_q];
  assign pwr_diff   = time_q - pdl_q;
  assign home_all   = {cfg.home_angles_high, cfg.home_angles_low};
  assign home       = home_all[{idx_q, 3'b000} +: HOME_W];

  always_comb begin
    rest        = mask_q;
    rest[idx_q] = 1'b0;
  end

  always_comb begin
    ang_raw = signed'({2'b00, home});
    if (note_q) begin
      if (cfg.direction_mask[idx_q]) begin
        ang_raw = ang_raw + signed'({3'b000, cfg.pluck_deg});
      end else begin
        ang_raw = ang_raw - signed'({3'b000, cfg.pluck_deg});
      end
    end
    ang_sat = ang_raw;
    if (ang_sat > AMAX_S) ang_sat = AMAX_S;
    if (ang_sat < AMIN_S) ang_sat = AMIN_S;
    ang_off  = HOME_W'(ang_sat - AMIN_S);
    pdiff    = signed'({1'b0, cfg.pulse_max}) - signed'({1'b0, cfg.pulse_min});
    prod     = signed'({1'b0, ang_off}) * pdiff;
    prod_abs = prod[21] ? 22'(-prod) : 22'(prod);
  end

  assign div_start = (state_q == ST_MUL) && SPAN_OK;
  assign q_lo      = div_quo[PULSE_W-1:0];

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    pdl_d       = pdl_q;
    pwr_d       = pwr_q;
    active_d    = active_q;
    mask_d      = mask_q;
    idx_d       = idx_q;
    note_d      = note_q;
    wv_d        = wv_q;
    last_d      = last_q;
    neg_d       = neg_q;
    pulse_d     = pulse_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rdl_we      = 1'b0;
    rdl_idx     = sel_idx;
    rdl_wdata   = time_q + TIME_W'(cfg.pluck_hold_ms);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.command == CMD_NOTE) begin
            if (sel_ok) begin
              active_d[sel_idx] = 1'b1;
              rdl_we  = 1'b1;
              pdl_d   = time_q + TIME_W'(cfg.power_hold_ms);
              pwr_d   = 1'b1;
              idx_d   = sel_idx;
              note_d  = 1'b1;
              wv_d    = 1'b1;
              last_d  = 1'b1;
              state_d = ST_MUL;
            end else begin
              wv_d    = 1'b0;
              last_d  = 1'b1;
              state_d = ST_PUSH;
            end
          end else begin
            time_d  = time_q + 1'b1;
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mask_d[idx_q] = active_q[idx_q] && !ret_diff[TIME_W-1];
        if (idx_q == IW'(SERVO_COUNT - 1)) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FIN: begin
        idx_d = '0;
        if (|mask_q) begin
          pdl_d   = time_q + TIME_W'(cfg.power_hold_ms);
          pwr_d   = (cfg.power_hold_ms != '0);
          state_d = ST_PICK;
        end else begin
          if (pwr_q && !pwr_diff[TIME_W-1]) pwr_d = 1'b0;
          wv_d    = 1'b0;
          last_d  = 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PICK: begin
        if (mask_q[idx_q]) begin
          active_d[idx_q] = 1'b0;
          mask_d[idx_q]   = 1'b0;
          last_d  = (rest == '0);
          note_d  = 1'b0;
          wv_d    = 1'b1;
          state_d = ST_MUL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_MUL: begin
        neg_d = prod[21];
        if (SPAN_OK) begin
          state_d = ST_DIV;
        end else begin
          pulse_d = cfg.pulse_min;
          state_d = ST_PUSH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pulse_d = neg_q ? (cfg.pulse_min - q_lo) : (cfg.pulse_min + q_lo);
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.write_valid     = wv_q;
          out_d.servo_index     = wv_q ? 4'(idx_q) : 4'd0;
          out_d.pulse_count     = wv_q ? pulse_q : '0;
          out_d.outputs_enabled = pwr_q;
          out_d.last            = last_q;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_PICK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      pdl_q       <= '0;
      pwr_q       <= 1'b0;
      active_q    <= '0;
      mask_q      <= '0;
      idx_q       <= '0;
      note_q      <= 1'b0;
      wv_q        <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      pdl_q       <= pdl_d;
      pwr_q       <= pwr_d;
      active_q    <= active_d;
      mask_q      <= mask_d;
      idx_q       <= idx_d;
      note_q      <= note_d;
      wv_q        <= wv_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    pulse_q <= pulse_d;
    out_q   <= out_d;
    if (rdl_we) begin
      rdl_q[rdl_idx] <= rdl_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef ASSERT_OFF
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_res_o.last) |-> !in_ready_o)
    else $error("non-final result pending while sequencer idle");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide step");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_res_o.write_valid) |-> out_res_o.last)
    else $error("result without write is not final");

  a_mask_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK) |-> ((mask_q & ~active_q) == '0))
    else $error("expired mask holds an inactive servo");
`endif

endmodule

`default_nettype wire

[verif/servo_pluck_timer_bank_checker.sv]
// ----------------------------------------------------------------------------
// servo_pluck_timer_bank_checker
// Watches the request, result and register ports of the servo pluck timer
// bank, keeps its own copy of time, servo deadlines, power hold and settings,
// and checks every servo write against the predicted sequence.
// ----------------------------------------------------------------------------
module servo_pluck_timer_bank_checker #(
  parameter int SERVO_COUNT = 16,
  parameter int ANGLE_MIN   = 0,
  parameter int ANGLE_MAX   = 180
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_o,
  input  spt_pkg::in_req_t          in_req_i,
  input  logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  spt_pkg::out_res_t         out_res_o,
  input  logic                      cfg_we_i,
  input  logic [spt_pkg::REG_W-1:0] cfg_idx_i,
  input  logic [spt_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                        pending_o,
  output int                        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

  cfg_t              setup;
  logic [TIME_W-1:0] now_ms;
  logic [15:0]       plucked;
  logic [TIME_W-1:0] return_at [MAX_SERVOS];
  logic              power_on;
  logic [TIME_W-1:0] power_off_at;
  out_res_t          servo_writes_due [$];
  int                mismatches = 0;

  assign errors_o = mismatches;

  task automatic report(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [PULSE_W-1:0] got,
                             input logic [PULSE_W-1:0] want);
    if (got !== want) begin
      report($sformatf("servo write %s is %0d, predicted %0d", name, got, want));
    end
  endtask

  function automatic int home_angle(input int s);
    logic [63:0] bank;
    bank = (s >= 8) ? setup.home_angles_high : setup.home_angles_low;
    return int'(bank[(s % 8) * 8 +: 8]);
  endfunction

  function automatic logic [PULSE_W-1:0] angle_pulse(input int angle);
    int a;
    int span;
    int q;
    a = angle;
    if (a > ANGLE_MAX) a = ANGLE_MAX;
    if (a < ANGLE_MIN) a = ANGLE_MIN;
    span = ANGLE_MAX - ANGLE_MIN;
    if (span <= 0) return setup.pulse_min;
    q = (a - ANGLE_MIN) * (int'(setup.pulse_max) - int'(setup.pulse_min)) / span;
    return PULSE_W'(int'(setup.pulse_min) + q);
  endfunction

  function automatic out_res_t servo_write(input logic wr, input int s,
                                           input logic [PULSE_W-1:0] pulse);
    out_res_t w;
    w = '0;
    w.write_valid = wr;
    w.servo_index = 4'(s);
    w.pulse_count = pulse;
    return w;
  endfunction

  task automatic extend_power();
    power_off_at = now_ms + TIME_W'(setup.power_hold_ms);
    power_on     = 1'b1;
  endtask

  task automatic predict_servo_writes(input in_req_t req);
    out_res_t step_q [$];
    int       s;
    int       angle;
    s = int'(req.servo_select);
    if (req.command == CMD_NOTE) begin
      if (s < SERVO_COUNT) begin
        angle = home_angle(s);
        if (setup.direction_mask[s]) angle += int'(setup.pluck_deg);
        else angle -= int'(setup.pluck_deg);
        extend_power();
        step_q.push_back(servo_write(1'b1, s, angle_pulse(angle)));
        plucked[s]   = 1'b1;
        return_at[s] = now_ms + TIME_W'(setup.pluck_hold_ms);
      end else begin
        step_q.push_back(servo_write(1'b0, 0, '0));
      end
    end else begin
      now_ms += 1;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (plucked[i] && (now_ms - return_at[i]) < HALF_RANGE) begin
          extend_power();
          step_q.push_back(servo_write(1'b1, i, angle_pulse(home_angle(i))));
          plucked[i] = 1'b0;
        end
      end
      if (power_on && (now_ms - power_off_at) < HALF_RANGE) power_on = 1'b0;
      if (step_q.size() == 0) step_q.push_back(servo_write(1'b0, 0, '0));
    end
    foreach (step_q[k]) begin
      step_q[k].outputs_enabled = power_on;
      step_q[k].last            = (k == step_q.size() - 1);
      servo_writes_due.push_back(step_q[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_res_t want;
    if (!rst_ni) begin
      setup        = '{RST_PLUCK_DEG, RST_PLUCK_HOLD, RST_POWER_HOLD, RST_DIRECTION,
                       RST_HOME, RST_HOME, RST_PULSE_MIN, RST_PULSE_MAX};
      now_ms       = '0;
      plucked      = '0;
      power_on     = 1'b0;
      power_off_at = '0;
      foreach (return_at[i]) return_at[i] = '0;
      servo_writes_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PLUCK_DEG:   setup.pluck_deg        = cfg_wdata_i[6:0];
          REG_PLUCK_HOLD:  setup.pluck_hold_ms    = cfg_wdata_i[15:0];
          REG_POWER_HOLD:  setup.power_hold_ms    = cfg_wdata_i[15:0];
          REG_DIRECTION:   setup.direction_mask   = cfg_wdata_i[15:0];
          REG_HOME_LOW:    setup.home_angles_low  = cfg_wdata_i;
          REG_HOME_HIGH:   setup.home_angles_high = cfg_wdata_i;
          REG_PULSE_MIN:   setup.pulse_min        = cfg_wdata_i[PULSE_W-1:0];
          REG_PULSE_MAX:   setup.pulse_max        = cfg_wdata_i[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_servo_writes(in_req_i);
      if (out_valid_o && out_ready_i) begin
        if (servo_writes_due.size() == 0) begin
          report($sformatf("servo write for servo %0d with no request behind it",
                           out_res_o.servo_index));
        end else begin
          want = servo_writes_due.pop_front();
          check_field("write_valid", out_res_o.write_valid, want.write_valid);
          check_field("servo_index", out_res_o.servo_index, want.servo_index);
          check_field("pulse_count", out_res_o.pulse_count, want.pulse_count);
          check_field("outputs_enabled", out_res_o.outputs_enabled,
                      want.outputs_enabled);
          check_field("last", out_res_o.last, want.last);
        end
      end
      pending_o <= servo_writes_due.size();
    end
  end

endmodule

[verif/servo_pluck_timer_bank_top_test.sv]
// ----------------------------------------------------------------------------
// servo_pluck_timer_bank_top_test
// Drives note and tick requests through the servo pluck timer bank under
// directed and random register settings, with random gaps and output stalls,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module servo_pluck_timer_bank_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  localparam int SERVO_COUNT = 16;
  localparam int ANGLE_MIN   = 0;
  localparam int ANGLE_MAX   = 180;
  localparam int PHASES      = 9;
  localparam int PHASE_REQS  = 28;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_req_t          in_req_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_res_t         out_res_o;
  logic             cfg_we_i    = 1'b0;
  logic [REG_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  int   writes_pending;
  int   errors;
  int   idle_pct = 30;
  logic calm     = 1'b0;
  int   stall_left;

  servo_pluck_timer_bank_top #(
    .SERVO_COUNT(SERVO_COUNT),
    .ANGLE_MIN  (ANGLE_MIN),
    .ANGLE_MAX  (ANGLE_MAX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  servo_pluck_timer_bank_checker #(
    .SERVO_COUNT(SERVO_COUNT),
    .ANGLE_MIN  (ANGLE_MIN),
    .ANGLE_MAX  (ANGLE_MAX)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (writes_pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("servo_pluck_timer_bank_top: mismatch");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct / 3) begin
      stall_left  <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_req(input cmd_e cmd, input logic [5:0] sel);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{command: cmd, servo_select: sel};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) send_req(CMD_TICK, 6'($urandom_range(0, 63)));
    else if (pick < 90) send_req(CMD_NOTE, 6'($urandom_range(0, SERVO_COUNT - 1)));
    else send_req(CMD_NOTE, 6'($urandom_range(SERVO_COUNT, 63)));
  endtask

  // hold until every predicted write is out and the block is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (writes_pending != 0 || !in_ready_o);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_setup(input logic [6:0] pluck, input logic [15:0] pluck_hold,
                            input logic [15:0] power_hold, input logic [15:0] dir_mask,
                            input logic [63:0] home_lo, input logic [63:0] home_hi,
                            input logic [11:0] pmin, input logic [11:0] pmax);
    logic [CFG_W-1:0] vals [8];
    vals = '{64'(pluck), 64'(pluck_hold), 64'(power_hold), 64'(dir_mask),
             home_lo, home_hi, 64'(pmin), 64'(pmax)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_hold(input int short_max);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(20, 300));
      default: return 16'($urandom_range(1, short_max));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(CMD_TICK, 6'd0);
    send_req(CMD_NOTE, 6'd0);
    send_req(CMD_NOTE, 6'd15);
    send_req(CMD_NOTE, 6'd16);
    send_req(CMD_NOTE, 6'd63);
    send_req(CMD_NOTE, 6'd0);
    send_req(CMD_TICK, 6'd63);
    drain();

    load_setup(7'd127, 16'd0, 16'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
               12'd4095, 12'd0);
    send_req(CMD_NOTE, 6'd0);
    send_req(CMD_NOTE, 6'd8);
    send_req(CMD_NOTE, 6'd15);
    send_req(CMD_TICK, 6'd21);
    send_req(CMD_TICK, 6'd42);
    send_req(CMD_NOTE, 6'd40);
    drain();

    load_setup(7'd0, 16'hFFFF, 16'hFFFF, 16'h0, 64'hB4B4_B4B4_B4B4_B4B4,
               64'h0001_B3B5_FE7F_5AB4, 12'd0, 12'd4095);
    send_req(CMD_NOTE, 6'd7);
    send_req(CMD_NOTE, 6'd9);
    send_req(CMD_NOTE, 6'd12);
    send_req(CMD_TICK, 6'd5);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        calm     <= 1'b1;
        idle_pct <= 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct <= 0;
          1:       idle_pct <= 15;
          default: idle_pct <= 50;
        endcase
      end
      load_setup(7'($urandom_range(0, 127)), pick_hold(12), pick_hold(40),
                 16'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      for (int k = 0; k < PHASE_REQS; k++) send_random_req();
      drain();
    end

    if (errors == 0) begin
      $display("servo_pluck_timer_bank_top: match");
    end else begin
      $display("servo_pluck_timer_bank_top: mismatch");
    end
    $finish;
  end

endmodule
